>>> rtl/core/box_filter_downscaler_defines.svh
// Assertion macros used by the box filter downscaler top level.
`ifndef BOX_FILTER_DOWNSCALER_DEFINES_SVH
`define BOX_FILTER_DOWNSCALER_DEFINES_SVH

// Same-cycle implication, checked on clk, off while rst is high.
`define BFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off while rst is high.
`define BFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/bfd_pkg.sv
// Shared types and constants of the box filter downscaler.
`timescale 1ns / 1ps
package bfd_pkg;

  localparam int NUM_CH     = 4;   // red, green, blue, alpha
  localparam int CH_W       = 8;
  localparam int CFG_W      = 13;  // widest register, source sizes
  localparam int DCFG_W     = 11;  // destination size registers
  localparam int POS_W      = 10;  // destination coordinate fields
  localparam int QUOT_STEPS = 8;   // one quotient bit per divider step
  localparam int STEP_W     = 3;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QUOT_STEPS - 1);

  typedef logic [CH_W-1:0] chan_t;
  typedef logic [1:0]      reg_index_t;

  localparam reg_index_t REG_SRC_WIDTH  = 2'd0;
  localparam reg_index_t REG_SRC_HEIGHT = 2'd1;
  localparam reg_index_t REG_DST_WIDTH  = 2'd2;
  localparam reg_index_t REG_DST_HEIGHT = 2'd3;

  localparam logic [CFG_W-1:0]  SRC_DIM_RESET = 13'd1024;
  localparam logic [DCFG_W-1:0] DST_DIM_RESET = 11'd1024;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RMW  = 3'b010,
    ST_DIV  = 3'b100
  } state_t;

endpackage

>>> rtl/core/bfd_div.sv
// Four-lane restoring divider producing 8-bit channel averages.
`timescale 1ns / 1ps
module bfd_div #(
  parameter int SUM_W = 32,
  parameter int CNT_W = 25
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  input  logic [bfd_pkg::NUM_CH*SUM_W-1:0]        sums,
  input  logic [CNT_W-1:0]                        count,
  output logic                                    done,
  output logic [bfd_pkg::NUM_CH*bfd_pkg::CH_W-1:0] quot
);

  localparam int DV_W = CNT_W + bfd_pkg::QUOT_STEPS - 1;
  localparam int CW   = (SUM_W > DV_W) ? SUM_W : DV_W;

  logic                         busy;
  logic [bfd_pkg::STEP_W-1:0]   step;
  logic [DV_W-1:0]              dvs;
  logic [SUM_W-1:0]             rem  [bfd_pkg::NUM_CH];
  bfd_pkg::chan_t               q    [bfd_pkg::NUM_CH];
  logic [CW-1:0]                diff [bfd_pkg::NUM_CH];
  logic                         ge   [bfd_pkg::NUM_CH];

  // Quotient is known to fit in 8 bits, so start with the divisor shifted by 7.
  always_comb begin
    for (int ch = 0; ch < bfd_pkg::NUM_CH; ch++) begin
      ge[ch]   = CW'(rem[ch]) >= CW'(dvs);
      diff[ch] = CW'(rem[ch]) - CW'(dvs);
      quot[ch*bfd_pkg::CH_W +: bfd_pkg::CH_W] = q[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (busy) begin
      step <= step + bfd_pkg::STEP_W'(1);
      if (step == bfd_pkg::STEP_LAST) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= DV_W'(count) << (bfd_pkg::QUOT_STEPS - 1);
      for (int ch = 0; ch < bfd_pkg::NUM_CH; ch++) begin
        rem[ch] <= sums[ch*SUM_W +: SUM_W];
        q[ch]   <= '0;
      end
    end else if (busy) begin
      dvs <= dvs >> 1;
      for (int ch = 0; ch < bfd_pkg::NUM_CH; ch++) begin
        if (ge[ch]) begin
          rem[ch] <= diff[ch][SUM_W-1:0];
        end
        q[ch] <= {q[ch][bfd_pkg::CH_W-2:0], ge[ch]};
      end
    end
  end

endmodule

>>> rtl/core/box_filter_downscaler.sv
// Box filter downscaler top level: RGBA8 raster in, block averages out.
// A pixel that closes no block goes through accept, then the sum read-modify-write.
// A pixel that closes a block goes through accept, update, 8 divider steps, then output load once the output is free.
// Those steps are set by the one-port sum memory and the one-bit-per-step divider.
// Reset (synchronous, active high) sets all sizes to 1024 and restarts the image at source (0, 0).
`timescale 1ns / 1ps
`include "box_filter_downscaler_defines.svh"
module box_filter_downscaler #(
  parameter int SRC_DIM_MAX = 4096,
  parameter int DST_DIM_MAX = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration write port
  input  logic                         cfg_wr_en,
  input  bfd_pkg::reg_index_t          cfg_index,
  input  logic [bfd_pkg::CFG_W-1:0]    cfg_data,
  // source pixel channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bfd_pkg::CH_W-1:0]     in_red,
  input  logic [bfd_pkg::CH_W-1:0]     in_green,
  input  logic [bfd_pkg::CH_W-1:0]     in_blue,
  input  logic [bfd_pkg::CH_W-1:0]     in_alpha,
  // destination pixel channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bfd_pkg::CH_W-1:0]     out_red,
  output logic [bfd_pkg::CH_W-1:0]     out_green,
  output logic [bfd_pkg::CH_W-1:0]     out_blue,
  output logic [bfd_pkg::CH_W-1:0]     out_alpha,
  output logic [bfd_pkg::POS_W-1:0]    out_col,
  output logic [bfd_pkg::POS_W-1:0]    out_row,
  output logic                         image_done
);

  // Effective sizes hold values up to SRC_DIM_MAX; coordinate counters hold
  // values below it. Destination indexes address the column sum memory.
  localparam int ES_W  = $clog2(SRC_DIM_MAX + 1);
  localparam int SC_W  = $clog2(SRC_DIM_MAX);
  localparam int DS_W  = $clog2(DST_DIM_MAX + 1);
  localparam int DC_W  = (DST_DIM_MAX > 1) ? $clog2(DST_DIM_MAX) : 1;
  localparam int GA_W  = (ES_W > bfd_pkg::CFG_W) ? ES_W : bfd_pkg::CFG_W;
  localparam int GW    = (GA_W > DS_W) ? GA_W : DS_W;
  // Pixel count of a block and per-channel sum of a block.
  localparam int CNT_W = $clog2(longint'(SRC_DIM_MAX) * SRC_DIM_MAX + 1);
  localparam int SUM_W = $clog2(longint'(255) * SRC_DIM_MAX * SRC_DIM_MAX + 1);
  localparam int MEM_W = bfd_pkg::NUM_CH * SUM_W;
  localparam int PX_W  = DC_W + bfd_pkg::POS_W;

  // ---------------------------------------------------------------------------
  // Configuration registers. Any write restarts the image at source (0, 0).
  // ---------------------------------------------------------------------------
  logic [bfd_pkg::CFG_W-1:0]  src_width, src_height;
  logic [bfd_pkg::DCFG_W-1:0] dst_width, dst_height;
  logic                       restart;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= bfd_pkg::SRC_DIM_RESET;
      src_height <= bfd_pkg::SRC_DIM_RESET;
      dst_width  <= bfd_pkg::DST_DIM_RESET;
      dst_height <= bfd_pkg::DST_DIM_RESET;
      restart    <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        bfd_pkg::REG_SRC_WIDTH:  src_width  <= cfg_data;
        bfd_pkg::REG_SRC_HEIGHT: src_height <= cfg_data;
        bfd_pkg::REG_DST_WIDTH:  dst_width  <= cfg_data[bfd_pkg::DCFG_W-1:0];
        bfd_pkg::REG_DST_HEIGHT: dst_height <= cfg_data[bfd_pkg::DCFG_W-1:0];
        default:                 src_width  <= src_width;
      endcase
      restart <= 1'b1;
    end else begin
      restart <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Effective sizes: clamp into range, then never upscale (dst <= src).
  // ---------------------------------------------------------------------------
  logic [GW-1:0]   sw_g, sh_g, dw_g, dh_g;
  logic [ES_W-1:0] eff_sw, eff_sh, eff_dw, eff_dh;
  logic [ES_W-1:0] sw_minus_dw, sh_minus_dh;

  always_comb begin
    sw_g = GW'(src_width);
    if (sw_g == '0)                        sw_g = GW'(1);
    else if (sw_g > GW'(SRC_DIM_MAX))      sw_g = GW'(SRC_DIM_MAX);
    sh_g = GW'(src_height);
    if (sh_g == '0)                        sh_g = GW'(1);
    else if (sh_g > GW'(SRC_DIM_MAX))      sh_g = GW'(SRC_DIM_MAX);
    dw_g = GW'(dst_width);
    if (dw_g == '0)                        dw_g = GW'(1);
    else if (dw_g > GW'(DST_DIM_MAX))      dw_g = GW'(DST_DIM_MAX);
    if (dw_g > sw_g)                       dw_g = sw_g;
    dh_g = GW'(dst_height);
    if (dh_g == '0)                        dh_g = GW'(1);
    else if (dh_g > GW'(DST_DIM_MAX))      dh_g = GW'(DST_DIM_MAX);
    if (dh_g > sh_g)                       dh_g = sh_g;
  end

  assign eff_sw      = ES_W'(sw_g);
  assign eff_sh      = ES_W'(sh_g);
  assign eff_dw      = ES_W'(dw_g);
  assign eff_dh      = ES_W'(dh_g);
  assign sw_minus_dw = eff_sw - eff_dw;
  assign sh_minus_dh = eff_sh - eff_dh;

  // ---------------------------------------------------------------------------
  // Raster position. Block edges floor(i*S/D) are tracked without division by
  // an error term e = (x+1)*S - (col+1)*D, which stays in [0, S) inside block
  // x. The column closes its block when e < D; step e by -D, plus S on a close.
  // The same scheme runs for rows, advanced once per source line.
  // ---------------------------------------------------------------------------
  logic [SC_W-1:0] src_col, src_row;
  logic [SC_W-1:0] col_span, row_span;  // columns/rows already in this block
  logic [DC_W-1:0] dst_col, dst_row;
  logic [ES_W-1:0] col_err, row_err;
  logic            col_first, row_first;
  logic            last_col, last_row, col_wrap, row_wrap;
  logic            accept;

  assign last_col = col_err < eff_dw;
  assign last_row = row_err < eff_dh;
  assign col_wrap = (ES_W'(src_col) + ES_W'(1)) == eff_sw;
  assign row_wrap = (ES_W'(src_row) + ES_W'(1)) == eff_sh;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      src_col   <= '0;
      src_row   <= '0;
      col_span  <= '0;
      row_span  <= '0;
      dst_col   <= '0;
      dst_row   <= '0;
      col_err   <= sw_minus_dw;
      row_err   <= sh_minus_dh;
      col_first <= 1'b1;
      row_first <= 1'b1;
    end else if (accept) begin
      if (col_wrap) begin
        // End of a source line: rewind columns, advance rows.
        src_col   <= '0;
        dst_col   <= '0;
        col_err   <= sw_minus_dw;
        col_first <= 1'b1;
        col_span  <= '0;
        if (row_wrap) begin
          // End of image: wrap to (0, 0) with the same sizes.
          src_row   <= '0;
          dst_row   <= '0;
          row_err   <= sh_minus_dh;
          row_first <= 1'b1;
          row_span  <= '0;
        end else begin
          src_row <= src_row + SC_W'(1);
          if (last_row) begin
            dst_row   <= dst_row + DC_W'(1);
            row_err   <= row_err + sh_minus_dh;
            row_first <= 1'b1;
            row_span  <= '0;
          end else begin
            row_err   <= row_err - eff_dh;
            row_first <= 1'b0;
            row_span  <= row_span + SC_W'(1);
          end
        end
      end else begin
        src_col <= src_col + SC_W'(1);
        if (last_col) begin
          dst_col   <= dst_col + DC_W'(1);
          col_err   <= col_err + sw_minus_dw;
          col_first <= 1'b1;
          col_span  <= '0;
        end else begin
          col_err   <= col_err - eff_dw;
          col_first <= 1'b0;
          col_span  <= col_span + SC_W'(1);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Hold the accepted pixel and its block flags for the update cycle.
  // ---------------------------------------------------------------------------
  bfd_pkg::chan_t  pix_hold [bfd_pkg::NUM_CH];
  logic            hold_first, hold_emit, hold_done;
  logic [DC_W-1:0] hold_slot, hold_row;
  logic [ES_W-1:0] hold_w, hold_h;

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_hold[0] <= in_red;
      pix_hold[1] <= in_green;
      pix_hold[2] <= in_blue;
      pix_hold[3] <= in_alpha;
      hold_first  <= col_first && row_first;
      hold_emit   <= last_col && last_row;
      hold_done   <= col_wrap && row_wrap;
      hold_slot   <= dst_col;
      hold_row    <= dst_row;
      hold_w      <= ES_W'(col_span) + ES_W'(1);
      hold_h      <= ES_W'(row_span) + ES_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Column sum memory: one entry per destination column, four channel sums.
  // Read on accept, written back in the following cycle. The next read comes
  // no earlier than the cycle after the write, so no forwarding is needed.
  // The first pixel of a block overwrites its entry; no clearing pass.
  // ---------------------------------------------------------------------------
  logic [MEM_W-1:0] sum_mem [DST_DIM_MAX];
  logic [MEM_W-1:0] rd_sums, new_sums;
  bfd_pkg::state_t  state;

  always_comb begin
    for (int ch = 0; ch < bfd_pkg::NUM_CH; ch++) begin
      new_sums[ch*SUM_W +: SUM_W] =
        (hold_first ? SUM_W'(0) : rd_sums[ch*SUM_W +: SUM_W]) + SUM_W'(pix_hold[ch]);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_sums <= sum_mem[dst_col];
    end
    if (state == bfd_pkg::ST_RMW) begin
      sum_mem[hold_slot] <= new_sums;
    end
  end

  // ---------------------------------------------------------------------------
  // Block average: pixel count = width * height, then floor(sum / count).
  // ---------------------------------------------------------------------------
  logic [2*ES_W-1:0] area;
  logic [CNT_W-1:0]  count;
  logic              div_start, div_done;
  logic [bfd_pkg::NUM_CH*bfd_pkg::CH_W-1:0] div_quot;

  assign area      = {ES_W'(0), hold_w} * {ES_W'(0), hold_h};
  assign count     = area[CNT_W-1:0];
  assign div_start = (state == bfd_pkg::ST_RMW) && hold_emit;

  bfd_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .sums  (new_sums),
    .count (count),
    .done  (div_done),
    .quot  (div_quot)
  );

  // ---------------------------------------------------------------------------
  // Sequencer. Take a pixel in IDLE, update its column sum, and when it closes
  // a block wait for the divider and a free output register.
  // ---------------------------------------------------------------------------
  logic out_free, out_load;

  assign out_free = !out_valid || out_ready;
  assign out_load = (state == bfd_pkg::ST_DIV) && div_done && out_free;
  assign in_ready = (state == bfd_pkg::ST_IDLE) && !restart;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfd_pkg::ST_IDLE;
    end else begin
      unique case (state)
        bfd_pkg::ST_IDLE: if (accept) begin
          state <= bfd_pkg::ST_RMW;
        end
        bfd_pkg::ST_RMW: begin
          state <= hold_emit ? bfd_pkg::ST_DIV : bfd_pkg::ST_IDLE;
        end
        bfd_pkg::ST_DIV: if (out_load) begin
          state <= bfd_pkg::ST_IDLE;
        end
        default: state <= bfd_pkg::ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: holds a finished pixel until the transfer completes, so
  // the next source pixel can be taken meanwhile.
  // ---------------------------------------------------------------------------
  logic [PX_W-1:0] col_ext, row_ext;

  assign col_ext = PX_W'(hold_slot);
  assign row_ext = PX_W'(hold_row);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_red    <= div_quot[0*bfd_pkg::CH_W +: bfd_pkg::CH_W];
      out_green  <= div_quot[1*bfd_pkg::CH_W +: bfd_pkg::CH_W];
      out_blue   <= div_quot[2*bfd_pkg::CH_W +: bfd_pkg::CH_W];
      out_alpha  <= div_quot[3*bfd_pkg::CH_W +: bfd_pkg::CH_W];
      out_col    <= col_ext[bfd_pkg::POS_W-1:0];
      out_row    <= row_ext[bfd_pkg::POS_W-1:0];
      image_done <= hold_done;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `BFD_ASSERT_NEXT(a_accept_to_rmw, accept, state == bfd_pkg::ST_RMW, "accepted pixel skipped the sum update")
  `BFD_ASSERT_NOW(a_col_err_range, !restart, col_err < eff_sw, "column error term left its range")
  `BFD_ASSERT_NOW(a_row_err_range, !restart, row_err < eff_sh, "row error term left its range")
  `BFD_ASSERT_NEXT(a_div_launch, div_start, (state == bfd_pkg::ST_DIV) && !div_done, "divider launch did not enter the divide state")

endmodule
